// ===== rtl/kfsu_pkg.sv =====
package kfsu_pkg;

  // Defaults for the top-level parameters
  localparam int STATE_DIM_DEF = 4;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int DATA_W  = 32;
  localparam int VAR_W   = 31;
  localparam int CNT_W   = 5;
  localparam int ACC_W   = 68;
  localparam int PROD_W  = 66;
  localparam int QD_W    = 41;

  // Stream widths
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 6;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 2;

  // ln 2 in Q0.32, held as a positive 33-bit multiplier operand
  localparam logic signed [32:0] LN2_Q32 = 33'sd2977044472;

  typedef enum logic [2:0] {
    KIND_TRN   = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_NOISE = 3'd2,
    KIND_MEAN  = 3'd3,
    KIND_COV   = 3'd4,
    KIND_OBS   = 3'd5,
    KIND_READ  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    TGT_MEAN = 2'd0,
    TGT_COV  = 2'd1,
    TGT_GAIN = 2'd2,
    TGT_PROP = 2'd3
  } target_t;

  // Datapath operations issued to the multiply-accumulate unit
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PZ,
    OP_F,
    OP_TPZ,
    OP_ZA,
    OP_VSQ,
    OP_SQX,
    OP_LN,
    OP_NA,
    OP_L,
    OP_TP,
    OP_PC
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DRAIN,
    ST_GAIN_CLR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_UPD,
    ST_LN_MUL,
    ST_LN_WAIT,
    ST_LL,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic             accept;
    op_t              op;
    logic [CNT_W-1:0] i;
    logic [CNT_W-1:0] j;
    logic [CNT_W-1:0] q;
    logic             first;
    logic             last;
    logic             div_start;
    logic             div_k;
    logic             norm_load;
    logic             norm_step;
    logic             ll_calc;
    logic             gain_clr;
    logic             commit;
    logic             rd_out;
    logic             obs_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic norm_done;
    logic out_free;
    logic missing;
  } sts_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7FFFFFFF);
    lo = -ACC_W'(64'sh80000000);
    if (x > hi) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo) begin
      return 32'sh80000000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/kfsu_ctrl.sv =====
module kfsu_ctrl #(
  parameter int STATE_DIM = kfsu_pkg::STATE_DIM_DEF,
  parameter int FRAC_BITS = kfsu_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [2:0]       in_kind,
  output logic             in_tready,
  output kfsu_pkg::cmd_t   cmd,
  input  kfsu_pkg::sts_t   sts
);
  import kfsu_pkg::*;

  localparam logic [CNT_W-1:0] NM1  = CNT_W'(STATE_DIM - 1);
  localparam logic [CNT_W-1:0] NN   = CNT_W'(STATE_DIM);
  localparam logic [CNT_W-1:0] FBM1 = CNT_W'(FRAC_BITS - 1);

  state_t           state_r, state_nxt;
  op_t              ph_r, ph_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, q_r, q_nxt;

  logic             accept;
  logic             is3d, usej, single;
  logic             last_q, last_j, last_i;
  logic [CNT_W-1:0] jmax;

  assign accept = in_tvalid && (state_r == ST_IDLE);

  // Loop shape of the current phase
  always_comb begin
    is3d   = (ph_r == OP_TP) || (ph_r == OP_PC);
    usej   = (ph_r == OP_PZ) || (ph_r == OP_TPZ) || (ph_r == OP_NA) || (ph_r == OP_L) || is3d;
    single = (ph_r == OP_VSQ) || (ph_r == OP_LN) || (ph_r == OP_SQX);
    jmax   = (ph_r == OP_NA) ? NN : NM1;
    last_q = is3d ? (q_r == NM1) : 1'b1;
    last_j = usej ? (j_r == jmax) : 1'b1;
    last_i = single ? 1'b1 : (i_r == NM1);
  end

  // Next state and loop counters
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    q_nxt     = q_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_OBS) begin
            state_nxt = ST_MAC;
            ph_nxt    = OP_PZ;
            i_nxt     = '0;
            j_nxt     = '0;
            q_nxt     = '0;
          end else if (in_kind == KIND_READ) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_MAC: begin
        // advance innermost counter first
        if (!last_q) begin
          q_nxt = q_r + 1'b1;
        end else begin
          q_nxt = '0;
          if (!last_j) begin
            j_nxt = j_r + 1'b1;
          end else begin
            j_nxt = '0;
            if (!last_i) begin
              i_nxt = i_r + 1'b1;
            end else begin
              i_nxt     = '0;
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        i_nxt = '0;
        j_nxt = '0;
        q_nxt = '0;
        case (ph_r)
          OP_PZ: begin
            state_nxt = ST_MAC;
            ph_nxt    = OP_F;
          end
          OP_F: begin
            if (sts.missing) begin
              state_nxt = ST_GAIN_CLR;
            end else begin
              state_nxt = ST_MAC;
              ph_nxt    = OP_TPZ;
            end
          end
          OP_TPZ: state_nxt = ST_DIV_GO;
          OP_ZA: begin
            state_nxt = ST_MAC;
            ph_nxt    = OP_VSQ;
          end
          OP_VSQ: state_nxt = ST_DIV_GO;
          OP_NA: begin
            state_nxt = ST_MAC;
            ph_nxt    = OP_L;
          end
          OP_L: begin
            state_nxt = ST_MAC;
            ph_nxt    = OP_TP;
          end
          OP_TP: begin
            state_nxt = ST_MAC;
            ph_nxt    = OP_PC;
          end
          OP_PC: state_nxt = ST_COMMIT;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_GAIN_CLR: begin
        state_nxt = ST_MAC;
        ph_nxt    = OP_NA;
      end
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (ph_r == OP_TPZ) begin
            if (i_r == NM1) begin
              state_nxt = ST_MAC;
              ph_nxt    = OP_ZA;
              i_nxt     = '0;
            end else begin
              state_nxt = ST_DIV_GO;
              i_nxt     = i_r + 1'b1;
            end
          end else begin
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (sts.norm_done) begin
          state_nxt = ST_SQ_MUL;
          q_nxt     = '0;
        end
      end
      ST_SQ_MUL: state_nxt = ST_SQ_UPD;
      ST_SQ_UPD: begin
        if (q_r == FBM1) begin
          state_nxt = ST_LN_MUL;
          q_nxt     = '0;
        end else begin
          state_nxt = ST_SQ_MUL;
          q_nxt     = q_r + 1'b1;
        end
      end
      ST_LN_MUL:  state_nxt = ST_LN_WAIT;
      ST_LN_WAIT: state_nxt = ST_LL;
      ST_LL: begin
        state_nxt = ST_MAC;
        ph_nxt    = OP_NA;
        i_nxt     = '0;
        j_nxt     = '0;
        q_nxt     = '0;
      end
      ST_COMMIT: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.accept = accept;
    cmd.i      = i_r;
    cmd.j      = j_r;
    cmd.q      = q_r;
    in_tready  = (state_r == ST_IDLE);
    case (state_r)
      ST_MAC: begin
        cmd.op = ph_r;
        case (ph_r)
          OP_PZ, OP_TPZ: begin
            cmd.first = (j_r == '0);
            cmd.last  = (j_r == NM1);
          end
          OP_NA: begin
            cmd.first = (j_r == '0);
            cmd.last  = (j_r == NN);
          end
          OP_F, OP_ZA: begin
            cmd.first = (i_r == '0);
            cmd.last  = (i_r == NM1);
          end
          OP_TP, OP_PC: begin
            cmd.first = (q_r == '0);
            cmd.last  = (q_r == NM1);
          end
          default: begin
            cmd.first = 1'b1;
            cmd.last  = 1'b1;
          end
        endcase
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_k     = (ph_r == OP_TPZ);
      end
      ST_DIV_WAIT: cmd.norm_load = sts.div_done && (ph_r != OP_TPZ);
      ST_NORM:     cmd.norm_step = 1'b1;
      ST_SQ_MUL:   cmd.op = OP_SQX;
      ST_LN_MUL:   cmd.op = OP_LN;
      ST_LL:       cmd.ll_calc = 1'b1;
      ST_GAIN_CLR: cmd.gain_clr = 1'b1;
      ST_COMMIT:   cmd.commit = 1'b1;
      ST_READ:     cmd.rd_out = sts.out_free;
      ST_RESULT:   cmd.obs_out = sts.out_free;
      default: ;
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= OP_NONE;
      i_r     <= '0;
      j_r     <= '0;
      q_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      q_r     <= q_nxt;
    end
  end

endmodule

// ===== rtl/kfsu_datapath.sv =====
module kfsu_datapath #(
  parameter int STATE_DIM = kfsu_pkg::STATE_DIM_DEF,
  parameter int FRAC_BITS = kfsu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kfsu_pkg::cmd_t      cmd,
  output kfsu_pkg::sts_t      sts,
  input  logic [2:0]          in_kind,
  input  logic [3:0]          in_row,
  input  logic [3:0]          in_col,
  input  logic signed [31:0]  in_value,
  input  logic signed [31:0]  in_observation,
  input  logic [30:0]         in_observation_variance,
  input  logic                in_is_missing,
  input  logic [1:0]          in_read_target,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_is_read,
  output logic signed [31:0]  out_innovation,
  output logic [30:0]         out_innovation_variance,
  output logic signed [31:0]  out_log_likelihood,
  output logic signed [31:0]  out_read_value,
  output logic                out_variance_fault
);
  import kfsu_pkg::*;

  localparam int N  = STATE_DIM;
  localparam int IW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam logic [63:0] LN2PI_R =
    (64'd7893621894 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  typedef logic signed [DATA_W-1:0] word_t;

  // Model state
  word_t tr_r [N][N];
  word_t pn_r [N][N];
  word_t pc_r [N][N];
  word_t pr_r [N][N];
  word_t ld_r [N];
  word_t mn_r [N];
  word_t gn_r [N];

  // Scratch values of one observation
  word_t tp_r  [N][N];
  word_t pz_r  [N];
  word_t tpz_r [N];
  word_t na_r  [N];

  // Captured item fields
  logic signed [31:0] y_r;
  logic [30:0]        h_r;
  logic               miss_r;
  logic [3:0]         row_r, col_r;
  logic [1:0]         tgt_r;

  // Observation results
  logic [30:0]        f_r;
  logic               fault_r;
  logic signed [31:0] v_r;
  logic signed [31:0] ll_r;
  logic signed [31:0] ln_r;
  logic [QD_W-1:0]    qd_r;

  // Multiply-accumulate pipeline
  logic signed [32:0]       ma, mb;
  logic signed [PROD_W-1:0] prod_r;
  op_t                      op1_r;
  logic [IW-1:0]            i1_r, j1_r;
  logic                     first1_r, last1_r;
  logic signed [ACC_W-1:0]  acc_r;

  // Divider
  logic [63:0]       dvd_r;
  logic [30:0]       rem_r;
  logic [5:0]        dcnt_r;
  logic              dbusy_r, dk_r, dsg_r;
  logic [IW-1:0]     di_r;

  // Log normalization and squaring
  logic [31:0]          x_r;
  logic [4:0]           m_r;
  logic [FRAC_BITS-1:0] frac_r;

  logic [IW-1:0] ci, cj, cq, cjm;
  logic [IW-1:0] rr, rc;
  logic          ld_rok, ld_mok, rd_rok, rd_mok;

  assign ci  = cmd.i[IW-1:0];
  assign cj  = cmd.j[IW-1:0];
  assign cq  = cmd.q[IW-1:0];
  assign cjm = (cmd.j == '0) ? '0 : IW'(cmd.j - 1'b1);
  assign rr  = row_r[IW-1:0];
  assign rc  = col_r[IW-1:0];

  assign ld_rok = ({1'b0, in_row} < 5'(N));
  assign ld_mok = ld_rok && ({1'b0, in_col} < 5'(N));
  assign rd_rok = ({1'b0, row_r} < 5'(N));
  assign rd_mok = rd_rok && ({1'b0, col_r} < 5'(N));

  function automatic logic signed [32:0] sx(input logic signed [31:0] a);
    return {a[31], a};
  endfunction

  // Select multiplier operands
  logic signed [31:0] l2;
  logic [31:0]        vmag;
  always_comb begin
    l2   = ((32'(signed'({1'b0, m_r})) - 32'(FRAC_BITS)) <<< FRAC_BITS)
           + 32'(frac_r);
    vmag = v_r[31] ? 32'(-v_r) : 32'(v_r);
    ma   = '0;
    mb   = '0;
    case (cmd.op)
      OP_PZ:  begin ma = sx(pc_r[ci][cj]); mb = sx(ld_r[cj]);  end
      OP_F:   begin ma = sx(ld_r[ci]);     mb = sx(pz_r[ci]);  end
      OP_TPZ: begin ma = sx(tr_r[ci][cj]); mb = sx(pz_r[cj]);  end
      OP_ZA:  begin ma = sx(ld_r[ci]);     mb = sx(mn_r[ci]);  end
      OP_VSQ: begin ma = {1'b0, vmag};     mb = {1'b0, vmag};  end
      OP_SQX: begin ma = {1'b0, x_r};      mb = {1'b0, x_r};   end
      OP_LN:  begin ma = sx(l2);           mb = LN2_Q32;       end
      OP_NA: begin
        if (cmd.j == '0) begin
          ma = sx(gn_r[ci]);
          mb = sx(v_r);
        end else begin
          ma = sx(tr_r[ci][cjm]);
          mb = sx(mn_r[cjm]);
        end
      end
      OP_L:   begin ma = sx(ld_r[ci]);     mb = sx(gn_r[cj]);  end
      OP_TP:  begin ma = sx(tr_r[ci][cq]); mb = sx(pc_r[cq][cj]); end
      OP_PC:  begin ma = sx(tp_r[ci][cq]); mb = sx(pr_r[cq][cj]); end
      default: ;
    endcase
  end

  // Register the product and its tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r <= OP_NONE;
    end else begin
      op1_r <= cmd.op;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      prod_r   <= ma * mb;
      i1_r     <= ci;
      j1_r     <= cj;
      first1_r <= cmd.first;
      last1_r  <= cmd.last;
    end
  end

  // Round the product to nearest, ties away from zero
  logic                     pneg;
  logic [PROD_W-1:0]        pmag, rmag;
  logic signed [PROD_W-1:0] term;
  always_comb begin
    pneg = prod_r[PROD_W-1];
    pmag = pneg ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    if (op1_r == OP_LN) begin
      rmag = (pmag + (PROD_W'(1) << 31)) >> 32;
    end else begin
      rmag = (pmag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
    term = pneg ? -signed'(rmag) : signed'(rmag);
  end

  // Accumulate with phase-dependent start value
  logic signed [ACC_W-1:0] base, sum, term_x;
  logic                    wr;
  always_comb begin
    term_x = ACC_W'(term);
    if (first1_r) begin
      case (op1_r)
        OP_F:  base = ACC_W'(signed'({1'b0, h_r}));
        OP_L:  base = ACC_W'(tr_r[j1_r][i1_r]);
        OP_PC: base = ACC_W'(pn_r[i1_r][j1_r]);
        default: base = '0;
      endcase
    end else begin
      base = acc_r;
    end
    sum = (op1_r == OP_L) ? base - term_x : base + term_x;
    wr  = (op1_r != OP_NONE) && last1_r;
  end

  always_ff @(posedge clk) begin
    acc_r <= sum;
  end

  // Divider step, quotient shifts into the dividend register
  logic [31:0] rem_sh;
  logic        ge;
  logic [30:0] rem_nxt;
  logic [63:0] quo;
  logic        dlast;
  logic [31:0] tmag;
  logic signed [31:0] ksat;
  always_comb begin
    rem_sh  = {rem_r, dvd_r[63]};
    ge      = (rem_sh >= {1'b0, f_r});
    rem_nxt = ge ? 31'(rem_sh - {1'b0, f_r}) : rem_sh[30:0];
    quo     = {dvd_r[62:0], ge};
    dlast   = dbusy_r && (dcnt_r == 6'd63);
    tmag    = tpz_r[ci][31] ? 32'(-tpz_r[ci]) : 32'(tpz_r[ci]);
    if (dsg_r) begin
      ksat = (quo > 64'h80000000) ? 32'sh80000000 : 32'(-quo[31:0]);
    end else begin
      ksat = (quo > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(quo[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= '0;
    end else if (dbusy_r) begin
      dcnt_r  <= dcnt_r + 1'b1;
      if (dlast) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      dk_r  <= cmd.div_k;
      di_r  <= ci;
      dsg_r <= cmd.div_k && tpz_r[ci][31];
      if (cmd.div_k) begin
        dvd_r <= 64'(tmag) << FRAC_BITS;
      end else begin
        dvd_r <= prod_r[63:0];
      end
    end else if (dbusy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= quo;
    end
  end

  // Log density sum, halved toward zero and negated
  logic signed [44:0] s, sh, nh;
  always_comb begin
    s  = $signed({2'b00, LN2PI_R[42:0]}) + {{13{ln_r[31]}}, ln_r} + $signed({4'b0, qd_r});
    sh = s[44] ? -((-s) >>> 1) : (s >>> 1);
    nh = -sh;
  end

  // Observation scalars, log stages and item capture
  logic [31:0] xs;
  assign xs = prod_r[61:30];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      y_r    <= in_observation;
      h_r    <= in_observation_variance;
      miss_r <= in_is_missing;
      row_r  <= in_row;
      col_r  <= in_col;
      tgt_r  <= in_read_target;
      v_r    <= '0;
      ll_r   <= '0;
    end else begin
      if (wr && op1_r == OP_F) begin
        if (sum <= 0) begin
          f_r     <= 31'd1;
          fault_r <= 1'b1;
        end else if (sum > ACC_W'(32'sh7FFFFFFF)) begin
          f_r     <= 31'h7FFFFFFF;
          fault_r <= 1'b0;
        end else begin
          f_r     <= sum[30:0];
          fault_r <= 1'b0;
        end
      end
      if (wr && op1_r == OP_ZA) begin
        v_r <= sat32(ACC_W'(y_r) - ACC_W'(sat32(sum)));
      end
      if (op1_r == OP_LN) ln_r <= term[31:0];
      if (cmd.ll_calc) ll_r <= sat32(ACC_W'(nh));
    end
    if (dlast && !dk_r) begin
      qd_r <= (quo > (64'd1 << 40)) ? QD_W'(64'd1 << 40) : quo[QD_W-1:0];
    end
    // normalize f, then square the mantissa once per bit
    if (cmd.norm_load) begin
      x_r    <= {1'b0, f_r};
      m_r    <= 5'd30;
      frac_r <= '0;
    end else if (cmd.norm_step && !(x_r[30] || m_r == '0)) begin
      x_r <= {x_r[30:0], 1'b0};
      m_r <= m_r - 1'b1;
    end else if (op1_r == OP_SQX) begin
      x_r    <= xs[31] ? (xs >> 1) : xs;
      frac_r <= {frac_r[FRAC_BITS-2:0], xs[31]};
    end
  end

  // Scratch vectors and matrices
  always_ff @(posedge clk) begin
    if (wr) begin
      case (op1_r)
        OP_PZ:  pz_r[i1_r]       <= sat32(sum);
        OP_TPZ: tpz_r[i1_r]      <= sat32(sum);
        OP_NA:  na_r[i1_r]       <= sat32(sum);
        OP_TP:  tp_r[i1_r][j1_r] <= sat32(sum);
        default: ;
      endcase
    end
  end

  // Model state: loads, updates and commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < N; a++) begin
        ld_r[a] <= '0;
        mn_r[a] <= '0;
        gn_r[a] <= '0;
        for (int b = 0; b < N; b++) begin
          tr_r[a][b] <= '0;
          pn_r[a][b] <= '0;
          pc_r[a][b] <= '0;
          pr_r[a][b] <= '0;
        end
      end
    end else begin
      if (cmd.accept) begin
        case (in_kind)
          KIND_TRN:   if (ld_mok) tr_r[in_row[IW-1:0]][in_col[IW-1:0]] <= in_value;
          KIND_LOAD:  if (ld_rok) ld_r[in_row[IW-1:0]] <= in_value;
          KIND_NOISE: if (ld_mok) pn_r[in_row[IW-1:0]][in_col[IW-1:0]] <= in_value;
          KIND_MEAN:  if (ld_rok) mn_r[in_row[IW-1:0]] <= in_value;
          KIND_COV:   if (ld_mok) pc_r[in_row[IW-1:0]][in_col[IW-1:0]] <= in_value;
          default: ;
        endcase
      end
      if (wr && op1_r == OP_L)  pr_r[i1_r][j1_r] <= sat32(sum);
      if (wr && op1_r == OP_PC) pc_r[i1_r][j1_r] <= sat32(sum);
      if (dlast && dk_r) gn_r[di_r] <= ksat;
      if (cmd.gain_clr) begin
        for (int a = 0; a < N; a++) gn_r[a] <= '0;
      end
      if (cmd.commit) begin
        for (int a = 0; a < N; a++) mn_r[a] <= na_r[a];
      end
    end
  end

  // Read mux
  logic signed [31:0] rd_val;
  always_comb begin
    rd_val = '0;
    case (tgt_r)
      TGT_MEAN: if (rd_rok) rd_val = mn_r[rr];
      TGT_COV:  if (rd_mok) rd_val = pc_r[rr][rc];
      TGT_GAIN: if (rd_rok) rd_val = gn_r[rr];
      TGT_PROP: if (rd_mok) rd_val = pr_r[rr][rc];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.rd_out || cmd.obs_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_out) begin
      out_is_read             <= 1'b1;
      out_innovation          <= '0;
      out_innovation_variance <= '0;
      out_log_likelihood      <= '0;
      out_read_value          <= rd_val;
      out_variance_fault      <= 1'b0;
    end else if (cmd.obs_out) begin
      out_is_read             <= 1'b0;
      out_innovation          <= v_r;
      out_innovation_variance <= f_r;
      out_log_likelihood      <= ll_r;
      out_read_value          <= '0;
      out_variance_fault      <= fault_r;
    end
  end

  // Status to the controller
  assign sts.div_done  = !dbusy_r;
  assign sts.norm_done = x_r[30] || (m_r == '0);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.missing   = miss_r;

endmodule

// ===== rtl/kalman_filter_scalar_update_top.sv =====
// Scalar-observation Kalman filter step in signed Q(32-FRAC_BITS).FRAC_BITS fixed
// point for a state of STATE_DIM entries. Load items (kind 0..4) write one entry of
// T, Z, RQR, a or P and produce no result. A read item (kind 6) returns one entry
// of a, P, K or L through the output register once it is free. An observe item
// (kind 5) runs predict and update on one shared 33x33 multiply-accumulate unit
// and a radix-2 divider; for N = STATE_DIM it performs N+1 divisions and two N^3
// matrix products, and it normalizes F before the log. A missing observation
// skips the gain, the divisions and the log. One item is in work at a time; the
// result sits in an output register, so loads may be taken while it waits.
module kalman_filter_scalar_update_top #(
  parameter int STATE_DIM = kfsu_pkg::STATE_DIM_DEF,
  parameter int FRAC_BITS = kfsu_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // row, col, value, observation, observation_variance, zero pad
  input  logic [kfsu_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind, is_missing, read_target
  input  logic [kfsu_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // innovation, innovation_variance, log_likelihood, read_value, zero pad
  output logic [kfsu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // is_read, variance_fault
  output logic [kfsu_pkg::OUT_TUSER_W-1:0]    out_tuser
);
  import kfsu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic               o_is_read, o_fault;
  logic signed [31:0] o_v, o_ll, o_rv;
  logic [30:0]        o_f;

  kfsu_ctrl #(
    .STATE_DIM (STATE_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser[2:0]),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  kfsu_datapath #(
    .STATE_DIM (STATE_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_kind                 (in_tuser[2:0]),
    .in_row                  (in_tdata[3:0]),
    .in_col                  (in_tdata[7:4]),
    .in_value                (in_tdata[39:8]),
    .in_observation          (in_tdata[71:40]),
    .in_observation_variance (in_tdata[102:72]),
    .in_is_missing           (in_tuser[3]),
    .in_read_target          (in_tuser[5:4]),
    .out_valid               (out_tvalid),
    .out_ready               (out_tready),
    .out_is_read             (o_is_read),
    .out_innovation          (o_v),
    .out_innovation_variance (o_f),
    .out_log_likelihood      (o_ll),
    .out_read_value          (o_rv),
    .out_variance_fault      (o_fault)
  );

  // Pack the result fields
  assign out_tdata = {1'b0, o_rv, o_ll, o_f, o_v};
  assign out_tuser = {o_fault, o_is_read};

endmodule
